FILE: rtl/core/skam_pkg.sv
// ============================================================================
// skam_pkg: shared types and constants for the sorted key/action map
// Field widths, status and command codes, controller states, result bundle.
// ============================================================================
package skam_pkg;

  localparam int KEY_W           = 32;
  localparam int ACT_W           = 8;
  localparam int OUT_CNT_W       = 5;
  localparam int TABLE_DEPTH_DEF = 16;

  localparam logic CMD_MAP    = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    SK_IDLE,
    SK_CMP,
    SK_DECIDE,
    SK_SHUP,
    SK_SHDN,
    SK_PUT,
    SK_DONE
  } skam_state_t;

  typedef struct packed {
    status_t              status;
    logic [ACT_W-1:0]     found_action;
    logic [OUT_CNT_W-1:0] position;
    logic [OUT_CNT_W-1:0] entry_count;
  } skam_result_t;

endpackage

FILE: rtl/core/skam_mem.sv
// ============================================================================
// skam_mem: entry storage
// One write port, one read port, read data registered.
// ============================================================================
module skam_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 40
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/skam_ctrl.sv
// ============================================================================
// skam_ctrl: search and shift sequencer
// Binary search over the memory, then update, insert-shift or remove-shift.
// ============================================================================
module skam_ctrl
  import skam_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             cmd,
  input  logic [KEY_W-1:0] key_code,
  input  logic [ACT_W-1:0] action_code,
  output logic             idle,
  output logic             res_valid,
  input  logic             res_ack,
  output skam_result_t     res
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int DW = KEY_W + ACT_W;

  skam_state_t      state_r, state_nxt;
  logic             cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [ACT_W-1:0] act_r, act_nxt;
  logic [CW-1:0]    lo_r, lo_nxt;
  logic [CW-1:0]    hi_r, hi_nxt;
  logic [IW-1:0]    mid_r, mid_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    vc_r, vc_nxt;
  logic             hit_r, hit_nxt;
  logic [ACT_W-1:0] found_r, found_nxt;
  status_t          status_r, status_nxt;

  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_waddr, mem_raddr;
  logic [DW-1:0]    mem_wdata, mem_rdata;

  logic [KEY_W-1:0] rkey;
  logic [ACT_W-1:0] ract;
  logic             key_lt, key_gt;
  logic [CW-1:0]    lo_cmp, hi_cmp, lo_s, hi_s;
  logic [CW:0]      sum_s;
  logic [IW-1:0]    mid_s;
  logic [CW-1:0]    idx_p1, idx_m1, pos_p1, vc_m1;
  logic [31:0]      pos_w, cnt_w;

  skam_mem #(
    .DEPTH (TABLE_DEPTH),
    .AW    (IW),
    .DW    (DW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // search step: compare against the entry fetched last cycle, pick next mid
  assign rkey   = mem_rdata[DW-1:ACT_W];
  assign ract   = mem_rdata[ACT_W-1:0];
  assign key_lt = key_r < rkey;
  assign key_gt = key_r > rkey;
  assign lo_cmp = key_gt ? CW'(mid_r) + CW'(1) : lo_r;
  assign hi_cmp = key_lt ? CW'(mid_r) : hi_r;
  assign lo_s   = (state_r == SK_CMP) ? lo_cmp : '0;
  assign hi_s   = (state_r == SK_CMP) ? hi_cmp : vc_r;
  assign sum_s  = {1'b0, lo_s} + {1'b0, hi_s};
  assign mid_s  = sum_s[IW:1];

  assign idx_p1 = idx_r + CW'(1);
  assign idx_m1 = idx_r - CW'(1);
  assign pos_p1 = pos_r + CW'(1);
  assign vc_m1  = vc_r - CW'(1);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    key_nxt    = key_r;
    act_nxt    = act_r;
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    mid_nxt    = mid_r;
    pos_nxt    = pos_r;
    idx_nxt    = idx_r;
    vc_nxt     = vc_r;
    hit_nxt    = hit_r;
    found_nxt  = found_r;
    status_nxt = status_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    idle       = 1'b0;
    res_valid  = 1'b0;

    unique case (state_r)
      SK_IDLE: begin
        idle = 1'b1;
        if (start) begin
          cmd_nxt   = cmd;
          key_nxt   = key_code;
          act_nxt   = action_code;
          found_nxt = '0;
          hit_nxt   = 1'b0;
          lo_nxt    = '0;
          hi_nxt    = vc_r;
          if (vc_r != '0) begin
            mem_re    = 1'b1;
            mem_raddr = mid_s;
            mid_nxt   = mid_s;
            state_nxt = SK_CMP;
          end else begin
            pos_nxt   = '0;
            state_nxt = SK_DECIDE;
          end
        end
      end

      SK_CMP: begin
        if (!key_lt && !key_gt) begin
          hit_nxt = 1'b1;
          pos_nxt = CW'(mid_r);
          if (cmd_r == CMD_LOOKUP) begin
            found_nxt = ract;
          end
          state_nxt = SK_DECIDE;
        end else begin
          lo_nxt = lo_cmp;
          hi_nxt = hi_cmp;
          if (lo_cmp < hi_cmp) begin
            mem_re    = 1'b1;
            mem_raddr = mid_s;
            mid_nxt   = mid_s;
          end else begin
            pos_nxt   = lo_cmp;
            state_nxt = SK_DECIDE;
          end
        end
      end

      SK_DECIDE: begin
        status_nxt = ST_OK;
        state_nxt  = SK_DONE;
        if (cmd_r == CMD_LOOKUP) begin
          if (!hit_r) begin
            status_nxt = ST_MISS;
          end
        end else if (act_r != '0) begin
          if (hit_r) begin
            mem_we    = 1'b1;
            mem_waddr = pos_r[IW-1:0];
            mem_wdata = {key_r, act_r};
          end else if (vc_r >= CW'(TABLE_DEPTH)) begin
            status_nxt = ST_FULL;
          end else if (vc_r > pos_r) begin
            // open a gap: move entries up, top first
            mem_re    = 1'b1;
            mem_raddr = vc_m1[IW-1:0];
            idx_nxt   = vc_m1;
            state_nxt = SK_SHUP;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = pos_r[IW-1:0];
            mem_wdata = {key_r, act_r};
            vc_nxt    = vc_r + CW'(1);
          end
        end else if (hit_r) begin
          if (pos_p1 < vc_r) begin
            // close the gap: move entries down, bottom first
            mem_re    = 1'b1;
            mem_raddr = pos_p1[IW-1:0];
            idx_nxt   = pos_p1;
            state_nxt = SK_SHDN;
          end else begin
            vc_nxt = vc_m1;
          end
        end
      end

      SK_SHUP: begin
        mem_we    = 1'b1;
        mem_waddr = idx_p1[IW-1:0];
        mem_wdata = mem_rdata;
        if (idx_r > pos_r) begin
          mem_re    = 1'b1;
          mem_raddr = idx_m1[IW-1:0];
          idx_nxt   = idx_m1;
        end else begin
          state_nxt = SK_PUT;
        end
      end

      SK_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r[IW-1:0];
        mem_wdata = {key_r, act_r};
        vc_nxt    = vc_r + CW'(1);
        state_nxt = SK_DONE;
      end

      SK_SHDN: begin
        mem_we    = 1'b1;
        mem_waddr = idx_m1[IW-1:0];
        mem_wdata = mem_rdata;
        if (idx_p1 < vc_r) begin
          mem_re    = 1'b1;
          mem_raddr = idx_p1[IW-1:0];
          idx_nxt   = idx_p1;
        end else begin
          vc_nxt    = vc_m1;
          state_nxt = SK_DONE;
        end
      end

      SK_DONE: begin
        res_valid = 1'b1;
        if (res_ack) begin
          state_nxt = SK_IDLE;
        end
      end

      default: begin
        state_nxt = SK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SK_IDLE;
      vc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      vc_r    <= vc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    key_r    <= key_nxt;
    act_r    <= act_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    mid_r    <= mid_nxt;
    pos_r    <= pos_nxt;
    idx_r    <= idx_nxt;
    hit_r    <= hit_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
  end

  // position and count wrap to the 5-bit output fields
  assign pos_w = 32'(pos_r);
  assign cnt_w = 32'(vc_r);

  always_comb begin
    res.status       = status_r;
    res.found_action = found_r;
    res.position     = pos_w[OUT_CNT_W-1:0];
    res.entry_count  = cnt_w[OUT_CNT_W-1:0];
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vc_r <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_no_rw_same: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re && (mem_waddr == mem_raddr)))
    else $error("read and write of one entry in the same cycle");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (vc_r != $past(vc_r)) |->
      ((vc_r == $past(vc_r) + CW'(1)) || (vc_r + CW'(1) == $past(vc_r))))
    else $error("entry count moved by more than one");

  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == SK_DONE) && res_ack |=> (state_r == SK_IDLE))
    else $error("result taken but sequencer did not return to idle");

endmodule

FILE: rtl/core/sorted_key_action_map.sv
// ============================================================================
// sorted_key_action_map: sorted key to action table with binary search
// Map, remove and lookup commands over a table kept in ascending key order.
// ============================================================================
//
//  channel | direction | transfer when          | payload
//  --------+-----------+------------------------+-------------------------------
//  in_     | input     | in_valid  & !in_stall  | cmd, key_code, action_code
//  out_    | output    | out_valid & !out_stall | status, found_action,
//          |           |                        | position, entry_count
//
//  Sequence: one command at a time. The accept cycle fetches the first probe;
//  each binary search step then compares that entry and fetches the next, up to
//  clog2(TABLE_DEPTH)+1 steps, followed by a decide state and a done state.
//  Insert and remove then move one entry per cycle (read and write share the
//  single memory port pair); insert then places the new entry in a put state.
//  Reset (rst_n low, synchronous) empties the table; no clearing pass.
//  in_stall is high while a command is in work; the output register lets a
//  new command start while a result still waits on out_stall.
//
module sorted_key_action_map
  import skam_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [KEY_W-1:0]     in_key_code,
  input  logic [ACT_W-1:0]     in_action_code,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_status,
  output logic [ACT_W-1:0]     out_found_action,
  output logic [OUT_CNT_W-1:0] out_position,
  output logic [OUT_CNT_W-1:0] out_entry_count
);

  logic         ctrl_idle;
  logic         res_valid;
  logic         res_load;
  skam_result_t res;

  logic         out_valid_r, out_valid_nxt;
  skam_result_t out_res_r;

  // sequencer: search, update and entry moves
  skam_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_valid && !in_stall),
    .cmd         (in_cmd),
    .key_code    (in_key_code),
    .action_code (in_action_code),
    .idle        (ctrl_idle),
    .res_valid   (res_valid),
    .res_ack     (res_load),
    .res         (res)
  );

  assign in_stall = !ctrl_idle;

  // output register: loads when empty or when its result transfers this cycle
  assign res_load = res_valid && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_res_r.status;
  assign out_found_action = out_res_r.found_action;
  assign out_position     = out_res_r.position;
  assign out_entry_count  = out_res_r.entry_count;

endmodule

FILE: test/sorted_key_action_map_check.sv
// ============================================================================
// sorted_key_action_map_check: result checker for the sorted key/action map
// Watches both channels, keeps its own copy of the table, predicts one result
// per accepted command and compares it field by field in arrival order.
// ============================================================================
module sorted_key_action_map_check
  import skam_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_cmd,
  input  logic [KEY_W-1:0]     in_key_code,
  input  logic [ACT_W-1:0]     in_action_code,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [1:0]           out_status,
  input  logic [ACT_W-1:0]     out_found_action,
  input  logic [OUT_CNT_W-1:0] out_position,
  input  logic [OUT_CNT_W-1:0] out_entry_count,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [KEY_W-1:0] table_keys [TABLE_DEPTH];
  logic [ACT_W-1:0] table_actions [TABLE_DEPTH];
  int               table_fill = 0;
  skam_result_t     expected_results [$];
  int               mismatches = 0;
  int               waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  // Applies one command to the shadow table and returns the result it gives.
  // Keys are strictly ascending, so the slot is the count of smaller keys.
  function automatic skam_result_t apply_command(input logic cmd,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [ACT_W-1:0] act);
    skam_result_t res;
    int           slot;
    bit           hit;
    slot = 0;
    while (slot < table_fill && table_keys[slot] < key) slot++;
    hit = (slot < table_fill) && (table_keys[slot] == key);
    res.status       = ST_OK;
    res.found_action = '0;
    if (cmd == CMD_LOOKUP) begin
      if (hit) res.found_action = table_actions[slot];
      else res.status = ST_MISS;
    end else if (act != '0) begin
      if (hit) begin
        table_actions[slot] = act;
      end else if (table_fill >= TABLE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        for (int i = table_fill; i > slot; i--) begin
          table_keys[i]    = table_keys[i-1];
          table_actions[i] = table_actions[i-1];
        end
        table_keys[slot]    = key;
        table_actions[slot] = act;
        table_fill++;
      end
    end else if (hit) begin
      for (int i = slot; i + 1 < table_fill; i++) begin
        table_keys[i]    = table_keys[i+1];
        table_actions[i] = table_actions[i+1];
      end
      table_fill--;
    end
    res.position    = OUT_CNT_W'(slot);
    res.entry_count = OUT_CNT_W'(table_fill);
    return res;
  endfunction

  always @(posedge clk) begin
    skam_result_t want;
    if (!rst_n) begin
      table_fill = 0;
      expected_results.delete();
    end else begin
      // result first: it can only belong to a command taken at an earlier edge
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_status);
            mismatches++;
          end
          if (out_found_action !== want.found_action) begin
            $error("found_action: expected %0d, actual %0d",
                   want.found_action, out_found_action);
            mismatches++;
          end
          if (out_position !== want.position) begin
            $error("position: expected %0d, actual %0d", want.position, out_position);
            mismatches++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   want.entry_count, out_entry_count);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(apply_command(in_cmd, in_key_code, in_action_code));
    end
    waiting = expected_results.size();
  end

endmodule

FILE: test/sorted_key_action_map_test.sv
// ============================================================================
// sorted_key_action_map_test: testbench top for the sorted key/action map
// Directed map, remove and lookup commands over empty, partly filled and full
// tables, then random command streams over key pools of varying size, with
// random idling on both channels. The checker predicts and compares.
// ============================================================================
module sorted_key_action_map_test;
  import skam_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = TABLE_DEPTH_DEF;
  localparam int PHASES      = 5;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_AT     = 260;   // accepted transfers before the long hold
  localparam int LONG_HOLD   = 300;   // cycles the receiver holds off

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_cmd = CMD_MAP;
  logic [KEY_W-1:0]     in_key_code = '0;
  logic [ACT_W-1:0]     in_action_code = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_status;
  logic [ACT_W-1:0]     out_found_action;
  logic [OUT_CNT_W-1:0] out_position;
  logic [OUT_CNT_W-1:0] out_entry_count;
  int                   fail_count;
  int                   pending;

  // no idling on either side while quiet is set
  bit                   quiet = 1'b0;
  int                   accepted_items = 0;
  logic [KEY_W-1:0]     key_pool [32];
  int                   pool_size = 8;

  always #5 clk = ~clk;

  sorted_key_action_map #(.TABLE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_key_code(in_key_code), .in_action_code(in_action_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_found_action(out_found_action),
    .out_position(out_position), .out_entry_count(out_entry_count)
  );

  sorted_key_action_map_check #(.TABLE_DEPTH(DEPTH)) checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_key_code(in_key_code), .in_action_code(in_action_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_found_action(out_found_action),
    .out_position(out_position), .out_entry_count(out_entry_count),
    .fail_count(fail_count), .pending(pending)
  );

  // input transfers seen so far; the receiver keys its long hold off this
  always @(posedge clk)
    if (rst_n && in_valid && !in_stall) accepted_items <= accepted_items + 1;

  // Idle length: mostly none or short, now and then long.
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Mostly keys from a small pool so that hits, updates, removes and a full
  // table all come up; the rest are the two extremes or any 32-bit value.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return key_pool[$urandom_range(0, pool_size - 1)];
    if (r < 73) return '0;
    if (r < 76) return '1;
    return $urandom;
  endfunction

  // One transfer: idle first if drawn, then hold the command until taken.
  // Valid stays high between back-to-back commands.
  task automatic send_command(input logic cmd, input logic [KEY_W-1:0] key,
                              input logic [ACT_W-1:0] act);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       = 1'b1;
    in_cmd         = cmd;
    in_key_code    = key;
    in_action_code = act;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic cmd;
    logic [ACT_W-1:0] act;
    cmd = 1'($urandom_range(0, 1));
    if (cmd == CMD_LOOKUP) act = ACT_W'($urandom_range(0, 255));   // don't care
    else if ($urandom_range(0, 3) == 0) act = '0;                  // remove
    else act = ACT_W'($urandom_range(1, 255));
    send_command(cmd, pick_key(), act);
  endtask

  // Result side: random stall stretches, plus one long hold-off that lets
  // the block back up onto its input.
  initial begin
    int  stall_left;
    bit  hold_done;
    stall_left = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && accepted_items >= HOLD_AT) begin
        hold_done = 1'b1;
        out_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall = 1'b0;
      end else if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall  = 1'b0;
        stall_left = idle_len();
      end
    end
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  initial begin
    int sizes [PHASES];
    sizes = '{6, 20, 24, 12, 30};

    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // --- directed part ---
    send_command(CMD_LOOKUP, 32'h1234_5678, 8'hA5);   // lookup miss on empty table
    send_command(CMD_MAP, 32'h0000_0001, 8'h00);      // remove of absent key
    send_command(CMD_MAP, 32'h8000_0000, 8'hFF);      // insert into empty table
    send_command(CMD_MAP, 32'h0000_0000, 8'h01);      // insert at the front
    send_command(CMD_MAP, 32'hFFFF_FFFF, 8'h80);      // insert at the back
    send_command(CMD_LOOKUP, 32'h0000_0000, 8'h00);   // hit, lowest key
    send_command(CMD_LOOKUP, 32'hFFFF_FFFF, 8'hFF);   // hit, highest key
    send_command(CMD_MAP, 32'h0000_0000, 8'h7F);      // update existing key
    send_command(CMD_MAP, 32'h8000_0000, 8'h00);      // remove present key
    send_command(CMD_LOOKUP, 32'h8000_0000, 8'h00);   // miss after remove
    // fill the table up to its depth
    for (int k = 1; k <= DEPTH - 2; k++)
      send_command(CMD_MAP, (KEY_W'(k) << 28) | 32'h55, ACT_W'(k * 17));
    send_command(CMD_MAP, 32'h4000_0000, 8'h03);      // insert into full table
    send_command(CMD_MAP, 32'h3000_0055, 8'h09);      // update in full table
    send_command(CMD_LOOKUP, 32'hFFFF_FFFF, 8'h00);   // hit at the last slot
    send_command(CMD_MAP, 32'h0000_0000, 8'h00);      // remove from full table

    // --- random part: phases over key pools of different sizes ---
    for (int p = 0; p < PHASES; p++) begin
      // one phase with no idling at all
      quiet = (p == 0);
      if (p == 3) begin
        // sender pause until everything outstanding has come back
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
      end
      pool_size = sizes[p];
      for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom;
      for (int i = 0; i < PHASE_ITEMS; i++) send_random();
    end
    in_valid = 1'b0;
    quiet    = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
